FILE: rtl/gf2_generator_matrix_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// GF(2) generator matrix encoder: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef GF2_GENERATOR_MATRIX_ENCODER_UNIT_MACROS_SVH
`define GF2_GENERATOR_MATRIX_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GF2E_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gf2e port check failed");

// Next-cycle implication, disabled during reset.
`define GF2E_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gf2e port check failed");

`endif

FILE: rtl/gf2e_pkg.sv
// ----------------------------------------------------------------------------
// GF(2) generator matrix encoder package
// Field widths, operation and register codes, state and lane control types.
// ----------------------------------------------------------------------------
package gf2e_pkg;

  localparam int WORD_W      = 64;
  localparam int WORD_SHIFT  = 6;
  localparam int CW_BITS_W   = 10;
  localparam int MSG_BITS_W  = 8;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_INDEX_W = 1;
  localparam int ROW_NUM_W   = 7;
  localparam int WORD_NUM_W  = 3;
  localparam int BYTE_W      = 8;
  localparam int BIT_SEL_W   = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_CODEWORD_BITS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_BITS  = 1'd1;

  localparam logic [CW_BITS_W-1:0]  CODEWORD_BITS_RST = 10'd512;
  localparam logic [MSG_BITS_W-1:0] MESSAGE_BITS_RST  = 8'd76;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_FLUSH,
    ST_EMIT
  } gf2e_state_e;

  typedef struct packed {
    logic rd_en;
    logic acc_en;
    logic clear;
  } gf2e_lane_ctrl_t;

endpackage

FILE: rtl/gf2e_stream_if.sv
// ----------------------------------------------------------------------------
// GF(2) generator matrix encoder stream interfaces
// Valid/ready channels for input items and codeword beats.
// ----------------------------------------------------------------------------
interface gf2e_in_if import gf2e_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [ROW_NUM_W-1:0]  row_number;
  logic [WORD_NUM_W-1:0] word_number;
  logic [WORD_W-1:0]     row_word;
  logic [BYTE_W-1:0]     message_byte;
  logic                  final_byte;

  modport source (
    output valid, operation, row_number, word_number, row_word, message_byte, final_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, row_number, word_number, row_word, message_byte, final_byte,
    output ready
  );
endinterface

interface gf2e_out_if import gf2e_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WORD_W-1:0]     codeword_word;
  logic [WORD_NUM_W-1:0] word_position;
  logic                  last_word;

  modport source (
    output valid, codeword_word, word_position, last_word,
    input  ready
  );
  modport sink (
    input  valid, codeword_word, word_position, last_word,
    output ready
  );
endinterface

FILE: rtl/gf2_generator_matrix_encoder_unit.sv
// ----------------------------------------------------------------------------
// GF(2) generator matrix encoder unit
// Binary linear block encoder: XOR of generator rows picked by message bits.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries load beats (one 64-bit word of one generator row) and encode
//          beats (one message byte, optionally flagged as the final byte).
//   out_if carries the codeword as 64-bit beats, least significant word first,
//          last_word set on the final beat.
//   cfg_*  writes codeword_bits (index 0) and message_bits (index 1); write
//          only while the block is idle.
// Sequence:
//   A load beat writes one lane memory and leaves the block idle. An encode
//   beat runs an accept cycle, eight row reads (one generator row per cycle
//   across all lanes, bounded by the single read port of each lane memory)
//   and a fold cycle. A final byte then starts the emit sequence, which loads
//   each codeword word into the output register, waiting on receiver stalls.
// Reset:
//   Clears the parity words, the byte position and the control state, and
//   restores codeword_bits to 512 and message_bits to 76. Generator rows are
//   undefined until loaded.
// Stalls:
//   A stalled output beat is held in the output register; the emit sequence
//   waits for it, and in_if.ready stays low until the last word is registered.
// ----------------------------------------------------------------------------
module gf2_generator_matrix_encoder_unit import gf2e_pkg::*; #(
  parameter int MAX_ROWS  = 128,
  parameter int MAX_WORDS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  gf2e_in_if.sink                in_if,
  gf2e_out_if.source             out_if,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int RAW        = $clog2(MAX_ROWS);
  localparam int BYTE_SLOTS = (MAX_ROWS + 7) / 8;
  localparam int BPW        = $clog2(BYTE_SLOTS + 1);
  localparam int RNW        = BPW + BIT_SEL_W;
  localparam int LW         = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW         = $clog2(MAX_WORDS + 1);
  localparam int LEN_W      = CW_BITS_W + 2;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WORD_W * MAX_WORDS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW_BITS_W-1:0]  cw_bits_q;
  logic [MSG_BITS_W-1:0] msg_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_bits_q  <= CODEWORD_BITS_RST;
      msg_bits_q <= MESSAGE_BITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CODEWORD_BITS: cw_bits_q  <= cfg_wdata_i[CW_BITS_W-1:0];
        REG_MESSAGE_BITS:  msg_bits_q <= cfg_wdata_i[MSG_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length to the storage, then derive the word count and the
  // number of live bits in the last word.
  logic [LEN_W-1:0]      len_ext;
  logic [LEN_W-1:0]      len_clamp;
  logic [LEN_W-1:0]      nwords_full;
  logic [CW-1:0]         nwords;
  logic [WORD_SHIFT-1:0] rem;

  assign len_ext     = LEN_W'(cw_bits_q);
  assign len_clamp   = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
  assign nwords_full = (len_clamp + LEN_W'(WORD_W - 1)) >> WORD_SHIFT;
  assign nwords      = CW'(nwords_full);
  assign rem         = len_clamp[WORD_SHIFT-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  gf2e_state_e          state_q, state_d;
  logic [BIT_SEL_W-1:0] bit_q, bit_d;
  logic [BPW-1:0]       pos_q, pos_d;
  logic [BYTE_W-1:0]    byte_q, byte_d;
  logic                 final_q, final_d;
  logic                 acc_en_q, acc_en_d;
  logic [CW-1:0]        k_q, k_d;

  logic                 in_fire;
  logic                 load_ok;
  logic [RNW-1:0]       row;
  logic                 sel;
  logic                 emit_last;
  logic                 merge_free;
  logic                 merge_load;
  gf2e_lane_ctrl_t      lane_ctrl;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;

  // Drop loads that fall outside the row storage; the word select below drops
  // words beyond the lane count.
  assign load_ok = in_fire && (in_if.operation == OP_LOAD)
                   && (32'(in_if.row_number) < MAX_ROWS);

  // Row picked by the current bit of the current byte; rows past the message
  // length or the storage count as zero, so skip the read and the fold.
  assign row = {pos_q, bit_q};
  assign sel = byte_q[bit_q] && (32'(row) < 32'(msg_bits_q)) && (32'(row) < MAX_ROWS);

  assign emit_last = ((k_q + CW'(1)) == nwords);

  always_comb begin
    state_d          = state_q;
    bit_d            = bit_q;
    pos_d            = pos_q;
    byte_d           = byte_q;
    final_d          = final_q;
    acc_en_d         = 1'b0;
    k_d              = k_q;
    merge_load       = 1'b0;
    lane_ctrl.rd_en  = 1'b0;
    lane_ctrl.acc_en = acc_en_q;
    lane_ctrl.clear  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_if.operation == OP_ENCODE)) begin
          byte_d  = in_if.message_byte;
          final_d = in_if.final_byte;
          bit_d   = '0;
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        // Read one row across all lanes per cycle; fold it in the next.
        lane_ctrl.rd_en = sel;
        acc_en_d        = sel;
        bit_d           = bit_q + BIT_SEL_W'(1);
        if (bit_q == '1) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // The last row folds in this cycle; advance or restart the byte count.
        if (final_q) begin
          pos_d   = '0;
          k_d     = '0;
          state_d = ST_EMIT;
        end else begin
          if (32'(pos_q) < BYTE_SLOTS) begin
            pos_d = pos_q + BPW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (nwords == '0) begin
          lane_ctrl.clear = 1'b1;
          state_d         = ST_IDLE;
        end else if (merge_free) begin
          merge_load = 1'b1;
          k_d        = k_q + CW'(1);
          if (emit_last) begin
            lane_ctrl.clear = 1'b1;
            k_d             = '0;
            state_d         = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bit_q    <= '0;
      pos_q    <= '0;
      byte_q   <= '0;
      final_q  <= 1'b0;
      acc_en_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      bit_q    <= bit_d;
      pos_q    <= pos_d;
      byte_q   <= byte_d;
      final_q  <= final_d;
      acc_en_q <= acc_en_d;
      k_q      <= k_d;
    end
  end

  // --------------------------------------------------------------------------
  // Lanes: one per 64-bit word of the codeword
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] lane_acc [MAX_WORDS];

  for (genvar l = 0; l < MAX_WORDS; l++) begin : g_lane
    gf2e_lane #(
      .ROWS (MAX_ROWS),
      .RAW  (RAW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (lane_ctrl),
      .lane_on_i (32'(l) < 32'(nwords)),
      .wr_en_i   (load_ok && (32'(in_if.word_number) == l)),
      .wr_addr_i (RAW'(in_if.row_number)),
      .wr_data_i (in_if.row_word),
      .rd_addr_i (RAW'(row)),
      .acc_o     (lane_acc[l])
    );
  end

  // --------------------------------------------------------------------------
  // Merge: serialize the lane words into registered output beats
  // --------------------------------------------------------------------------
  gf2e_merge #(
    .LANES (MAX_WORDS),
    .LW    (LW),
    .CW    (CW)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (lane_acc),
    .word_idx_i (k_q),
    .last_i     (emit_last),
    .rem_i      (rem),
    .load_i     (merge_load),
    .free_o     (merge_free),
    .out_if     (out_if)
  );

endmodule

FILE: rtl/gf2e_lane.sv
// ----------------------------------------------------------------------------
// GF(2) encoder lane
// Holds one 64-bit word column of the generator matrix and its parity word.
// ----------------------------------------------------------------------------
module gf2e_lane import gf2e_pkg::*; #(
  parameter int ROWS = 128,
  parameter int RAW  = $clog2(ROWS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gf2e_lane_ctrl_t   ctrl_i,
  input  logic              lane_on_i,
  input  logic              wr_en_i,
  input  logic [RAW-1:0]    wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic [RAW-1:0]    rd_addr_i,
  output logic [WORD_W-1:0] acc_o
);

  logic [WORD_W-1:0] mem_q [ROWS];
  logic [WORD_W-1:0] rd_data_q;
  logic [WORD_W-1:0] acc_q;
  logic [WORD_W-1:0] acc_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Fold the row word read last cycle into the parity word.
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en && lane_on_i) begin
      acc_d = acc_q ^ rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/gf2e_merge.sv
// ----------------------------------------------------------------------------
// GF(2) encoder merge stage
// Picks one lane's parity word, masks the tail and registers the output beat.
// ----------------------------------------------------------------------------
module gf2e_merge import gf2e_pkg::*; #(
  parameter int LANES = 8,
  parameter int LW    = 3,
  parameter int CW    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WORD_W-1:0] acc_i [LANES],
  input  logic [CW-1:0]     word_idx_i,
  input  logic              last_i,
  input  logic [WORD_SHIFT-1:0] rem_i,
  input  logic              load_i,
  output logic              free_o,
  gf2e_out_if.source        out_if
);

  logic                  valid_q;
  logic [WORD_W-1:0]     word_q;
  logic [WORD_NUM_W-1:0] pos_q;
  logic                  last_q;
  logic [WORD_W-1:0]     word_d;

  always_comb begin
    word_d = acc_i[word_idx_i[LW-1:0]];
    if (last_i && (rem_i != '0)) begin
      word_d = word_d & ~({WORD_W{1'b1}} << rem_i);
    end
  end

  assign free_o = !valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_if.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_d;
      pos_q  <= WORD_NUM_W'(word_idx_i);
      last_q <= last_i;
    end
  end

  assign out_if.valid         = valid_q;
  assign out_if.codeword_word = word_q;
  assign out_if.word_position = pos_q;
  assign out_if.last_word     = last_q;

endmodule

FILE: rtl/gf2e_checker.sv
// ----------------------------------------------------------------------------
// GF(2) encoder port checker
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "gf2_generator_matrix_encoder_unit_macros.svh"

module gf2e_checker import gf2e_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [WORD_W-1:0]     out_word_i,
  input logic [WORD_NUM_W-1:0] out_pos_i,
  input logic                  out_last_i
);

  logic [WORD_NUM_W-1:0] exp_pos_q;

  // Track the position the next beat must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      exp_pos_q <= out_last_i ? '0 : exp_pos_q + WORD_NUM_W'(1);
    end
  end

  `GF2E_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i) && $stable(out_pos_i) && $stable(out_last_i))
  `GF2E_ASSERT_IMPL(a_pos_seq, clk_i, rst_ni, out_valid_i, out_pos_i == exp_pos_q)
  `GF2E_ASSERT_IMPL(a_busy_emit, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)

endmodule

bind gf2_generator_matrix_encoder_unit gf2e_checker u_gf2e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_word_i  (out_if.codeword_word),
  .out_pos_i   (out_if.word_position),
  .out_last_i  (out_if.last_word)
);
